FILE: hdl/mdcq_pkg.sv
package mdcq_pkg;

   localparam int unsigned CNT_W = 48;
   localparam int unsigned WAIT_W = 16;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_READ_OCC = 2'd1;
   localparam logic [1:0] OP_READ_QUEUE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ARRIVAL_RATE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVICE_TIME = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_COUNT = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] random_draw;
      logic [7:0]  bin_index;
   } req_type;

   typedef struct packed {
      logic [6:0]       parked_count;
      logic [15:0]      queue_length;
      logic             departed;
      logic             arrival_queued;
      logic [CNT_W-1:0] arrivals_total;
      logic [CNT_W-1:0] queued_total;
      logic [CNT_W-1:0] queue_time_total;
      logic [39:0]      bin_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HREAD,
      ST_HUPD,
      ST_DEC_RD,
      ST_DEC_WR,
      ST_DEPART,
      ST_ARRIVE
   } state_type;

endpackage

FILE: hdl/multi_server_queue_tick_simulator_core.sv
// Parking queue simulator. After reset the block sweeps both histogram memories to zero,
// one entry per cycle for max(QUEUE_BINS, MAX_SPACES+1) entries, taking no word meanwhile.
// A read word steps through histogram read, update and result. A tick word with cars parked
// adds a timer read and write per car and a departure step before its result: a single
// read-decrement-write unit walks the timer memory one car at a time. A word whose result
// finds the previous result still waiting holds in its last step until it is taken.
module multi_server_queue_tick_simulator_core
   import mdcq_pkg::*;
#(
   parameter int unsigned MAX_SPACES = 64,
   parameter int unsigned QUEUE_BINS = 256,
   parameter int unsigned BIN_WIDTH = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned SLOT_W = MAX_SPACES > 1 ? $clog2(MAX_SPACES) : 1;
   localparam int unsigned PC_W = $clog2(MAX_SPACES + 1);
   localparam int unsigned OCC_N = MAX_SPACES + 1;
   localparam int unsigned OCC_AW = $clog2(OCC_N);
   localparam int unsigned Q_AW = $clog2(QUEUE_BINS);
   localparam int unsigned CLR_N = QUEUE_BINS > OCC_N ? QUEUE_BINS : OCC_N;
   localparam int unsigned CLR_W = $clog2(CLR_N);
   localparam logic [BIN_WIDTH-1:0] BIN_MAX = {BIN_WIDTH{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   logic [PC_W-1:0]       dec_i_ff, dec_i_in;
   logic [SLOT_W-1:0]     oldest_ff, oldest_in;
   logic [PC_W-1:0]       parked_ff, parked_in;
   logic [WAIT_W-1:0]     waiting_ff, waiting_in;
   logic [CNT_W-1:0]      arr_ff, arr_in;
   logic [CNT_W-1:0]      qd_ff, qd_in;
   logic [CNT_W-1:0]      wsum_ff, wsum_in;
   logic [11:0]           rate_ff, rate_in;
   logic [15:0]           svc_ff, svc_in;
   logic [6:0]            spc_ff, spc_in;
   logic [CLR_W-1:0]      clr_ff, clr_in;
   logic                  ozero_ff, ozero_in;
   logic                  departed_ff, departed_in;
   logic [BIN_WIDTH-1:0]  bin_val_ff, bin_val_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  occ_we, occ_re, q_we, q_re, tm_we, tm_re;
   logic [OCC_AW-1:0]     occ_wa, occ_ra;
   logic [Q_AW-1:0]       q_wa, q_ra;
   logic [SLOT_W-1:0]     tm_wa, tm_ra;
   logic [BIN_WIDTH-1:0]  occ_wd, occ_rd, q_wd, q_rd;
   logic [15:0]           tm_wd, tm_rd;

   logic [31:0]           bin_wide, qbin_wide, cap_wide, slot_sum, park_sum, clr_wide;
   logic [PC_W-1:0]       cap;
   logic [SLOT_W-1:0]     dec_slot, park_slot;
   logic [CNT_W:0]        wsum_add;

   mdcq_ram #(.WIDTH(BIN_WIDTH), .DEPTH(OCC_N)) u_occ_ram (
      .clock(clock), .wr_en(occ_we), .wr_addr(occ_wa), .wr_data(occ_wd),
      .rd_en(occ_re), .rd_addr(occ_ra), .rd_data(occ_rd)
   );

   mdcq_ram #(.WIDTH(BIN_WIDTH), .DEPTH(QUEUE_BINS)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_en(q_re), .rd_addr(q_ra), .rd_data(q_rd)
   );

   mdcq_ram #(.WIDTH(16), .DEPTH(MAX_SPACES)) u_timer_ram (
      .clock(clock), .wr_en(tm_we), .wr_addr(tm_wa), .wr_data(tm_wd),
      .rd_en(tm_re), .rd_addr(tm_ra), .rd_data(tm_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         oldest_ff <= '0;
         parked_ff <= '0;
         waiting_ff <= '0;
         arr_ff <= '0;
         qd_ff <= '0;
         wsum_ff <= '0;
         rate_ff <= 12'd100;
         svc_ff <= 16'd100;
         spc_ff <= 7'd5;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         oldest_ff <= oldest_in;
         parked_ff <= parked_in;
         waiting_ff <= waiting_in;
         arr_ff <= arr_in;
         qd_ff <= qd_in;
         wsum_ff <= wsum_in;
         rate_ff <= rate_in;
         svc_ff <= svc_in;
         spc_ff <= spc_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      dec_i_ff <= dec_i_in;
      ozero_ff <= ozero_in;
      departed_ff <= departed_in;
      bin_val_ff <= bin_val_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      bin_wide = 32'(req_ff.bin_index);
      qbin_wide = 32'(waiting_ff) < (QUEUE_BINS - 1) ? 32'(waiting_ff) : QUEUE_BINS - 1;
      cap_wide = 32'(spc_ff) < MAX_SPACES ? 32'(spc_ff) : MAX_SPACES;
      cap = cap_wide[PC_W-1:0];
      clr_wide = 32'(clr_ff);
      slot_sum = 32'(oldest_ff) + 32'(dec_i_ff);
      if (slot_sum >= MAX_SPACES) begin
         slot_sum = slot_sum - MAX_SPACES;
      end
      dec_slot = slot_sum[SLOT_W-1:0];
      park_sum = 32'(oldest_ff) + 32'(parked_ff);
      if (park_sum >= MAX_SPACES) begin
         park_sum = park_sum - MAX_SPACES;
      end
      park_slot = park_sum[SLOT_W-1:0];
      wsum_add = {1'b0, wsum_ff} + (CNT_W + 1)'(waiting_ff);

      state_in = state_ff;
      req_in = req_ff;
      dec_i_in = dec_i_ff;
      oldest_in = oldest_ff;
      parked_in = parked_ff;
      waiting_in = waiting_ff;
      arr_in = arr_ff;
      qd_in = qd_ff;
      wsum_in = wsum_ff;
      rate_in = rate_ff;
      svc_in = svc_ff;
      spc_in = spc_ff;
      clr_in = clr_ff;
      ozero_in = ozero_ff;
      departed_in = departed_ff;
      bin_val_in = bin_val_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;

      occ_we = 1'b0;
      occ_re = 1'b0;
      occ_ra = 32'(parked_ff) <= MAX_SPACES ? OCC_AW'(parked_ff) : '0;
      occ_wa = occ_ra;
      occ_wd = '0;
      q_we = 1'b0;
      q_re = 1'b0;
      q_ra = qbin_wide[Q_AW-1:0];
      q_wa = q_ra;
      q_wd = '0;
      tm_we = 1'b0;
      tm_wa = dec_slot;
      tm_wd = '0;
      tm_re = 1'b0;
      tm_ra = dec_slot;

      if (csr_we) begin
         case (csr_index)
            CSR_ARRIVAL_RATE: rate_in = csr_wdata[11:0];
            CSR_SERVICE_TIME: svc_in = csr_wdata;
            CSR_SPACE_COUNT: spc_in = csr_wdata[6:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            occ_we = clr_wide < OCC_N;
            occ_wa = clr_ff[OCC_AW-1:0];
            q_we = clr_wide < QUEUE_BINS;
            q_wa = clr_ff[Q_AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_wide == CLR_N - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               departed_in = 1'b0;
               state_in = ST_HREAD;
            end
         end
         ST_HREAD: begin
            occ_re = 1'b1;
            q_re = 1'b1;
            if (req_ff.op != OP_TICK) begin
               occ_ra = bin_wide[OCC_AW-1:0];
               q_ra = bin_wide[Q_AW-1:0];
            end
            state_in = ST_HUPD;
         end
         ST_HUPD: begin
            bin_val_in = '0;
            state_in = ST_ARRIVE;
            case (req_ff.op)
               OP_TICK: begin
                  occ_we = 1'b1;
                  occ_wd = occ_rd == BIN_MAX ? occ_rd : occ_rd + 1'b1;
                  q_we = 1'b1;
                  q_wd = q_rd == BIN_MAX ? q_rd : q_rd + 1'b1;
                  wsum_in = wsum_add[CNT_W] ? CNT_MAX : wsum_add[CNT_W-1:0];
                  dec_i_in = '0;
                  if (parked_ff != '0) begin
                     state_in = ST_DEC_RD;
                  end
               end
               OP_READ_OCC: begin
                  if (bin_wide <= MAX_SPACES) begin
                     bin_val_in = occ_rd;
                  end
               end
               OP_READ_QUEUE: begin
                  if (bin_wide < QUEUE_BINS) begin
                     bin_val_in = q_rd;
                  end
               end
               default: ;
            endcase
         end
         ST_DEC_RD: begin
            tm_re = 1'b1;
            state_in = ST_DEC_WR;
         end
         ST_DEC_WR: begin
            tm_we = 1'b1;
            tm_wd = tm_rd == '0 ? tm_rd : tm_rd - 1'b1;
            if (dec_i_ff == '0) begin
               ozero_in = tm_rd <= 16'd1;
            end
            dec_i_in = dec_i_ff + 1'b1;
            state_in = (dec_i_ff + 1'b1 == parked_ff) ? ST_DEPART : ST_DEC_RD;
         end
         ST_DEPART: begin
            state_in = ST_ARRIVE;
            if (ozero_ff) begin
               departed_in = 1'b1;
               oldest_in = 32'(oldest_ff) + 1 >= MAX_SPACES ? '0 : oldest_ff + 1'b1;
               parked_in = parked_ff - 1'b1;
               if (waiting_ff != '0 && parked_ff - 1'b1 < cap) begin
                  tm_we = 1'b1;
                  tm_wa = park_slot;
                  tm_wd = svc_ff;
                  parked_in = parked_ff;
                  waiting_in = waiting_ff - 1'b1;
               end
            end
         end
         ST_ARRIVE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.departed = departed_ff;
               rsp_in.arrival_queued = 1'b0;
               if (req_ff.op == OP_TICK && req_ff.random_draw <= rate_ff) begin
                  arr_in = arr_ff == CNT_MAX ? arr_ff : arr_ff + 1'b1;
                  if (parked_ff < cap) begin
                     tm_we = 1'b1;
                     tm_wa = park_slot;
                     tm_wd = svc_ff;
                     parked_in = parked_ff + 1'b1;
                  end else begin
                     rsp_in.arrival_queued = 1'b1;
                     waiting_in = waiting_ff == WAIT_MAX ? waiting_ff : waiting_ff + 1'b1;
                     qd_in = qd_ff == CNT_MAX ? qd_ff : qd_ff + 1'b1;
                  end
               end
               rsp_in.parked_count = 7'(parked_in);
               rsp_in.queue_length = waiting_in;
               rsp_in.arrivals_total = arr_in;
               rsp_in.queued_total = qd_in;
               rsp_in.queue_time_total = wsum_ff;
               rsp_in.bin_count = 40'(bin_val_ff);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/mdcq_ram.sv
module mdcq_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: verif/tb_multi_server_queue_tick_simulator_core.sv
module tb_multi_server_queue_tick_simulator_core;
   import mdcq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned SLOTS = 64;
   localparam int unsigned QBINS = 256;
   localparam logic [47:0] CNT_SAT = 48'hFFFF_FFFF_FFFF;
   localparam logic [39:0] BIN_SAT = 40'hFF_FFFF_FFFF;
   localparam int unsigned DRAIN_CYCLES = 200;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ARRIVAL_RATE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   multi_server_queue_tick_simulator_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the parking lot.
   logic [11:0] lot_rate;
   logic [15:0] lot_service;
   logic [6:0]  lot_spaces;
   logic [15:0] car_timer [SLOTS];
   int          head_slot;
   int          cars_parked;
   int          cars_waiting;
   logic [39:0] occ_bins [SLOTS+1];
   logic [39:0] wait_bins [QBINS];
   logic [47:0] arrivals_seen;
   logic [47:0] queued_seen;
   logic [47:0] wait_accum;

   rsp_type expected_rsps [$];
   int errors = 0;
   int words_sent = 0;
   int ticks_sent = 0;
   int rsps_checked = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int receiver_hold = 0;

   function automatic logic [39:0] bump_bin(logic [39:0] v);
      return (v == BIN_SAT) ? v : v + 40'd1;
   endfunction

   function automatic logic [47:0] bump_cnt(logic [47:0] v);
      return (v == CNT_SAT) ? v : v + 48'd1;
   endfunction

   function automatic rsp_type park_step(req_type w);
      int cap;
      int qbin;
      int s;
      logic [48:0] sum;
      rsp_type r;
      r = '0;
      if (w.op == OP_TICK) begin
         cap = (lot_spaces < SLOTS) ? int'(lot_spaces) : SLOTS;
         qbin = (cars_waiting < QBINS - 1) ? cars_waiting : QBINS - 1;
         occ_bins[cars_parked] = bump_bin(occ_bins[cars_parked]);
         wait_bins[qbin] = bump_bin(wait_bins[qbin]);
         sum = {1'b0, wait_accum} + 49'(cars_waiting);
         wait_accum = (sum > {1'b0, CNT_SAT}) ? CNT_SAT : sum[47:0];
         if (cars_parked > 0) begin
            for (int i = 0; i < cars_parked; i++) begin
               s = (head_slot + i) % SLOTS;
               if (car_timer[s] != 0) car_timer[s] = car_timer[s] - 16'd1;
            end
            if (car_timer[head_slot] == 0) begin
               r.departed = 1'b1;
               head_slot = (head_slot + 1) % SLOTS;
               cars_parked--;
               if (cars_waiting > 0 && cars_parked < cap) begin
                  car_timer[(head_slot + cars_parked) % SLOTS] = lot_service;
                  cars_parked++;
                  cars_waiting--;
               end
            end
         end
         if (w.random_draw <= lot_rate) begin
            arrivals_seen = bump_cnt(arrivals_seen);
            if (cars_parked < cap) begin
               car_timer[(head_slot + cars_parked) % SLOTS] = lot_service;
               cars_parked++;
            end else begin
               r.arrival_queued = 1'b1;
               if (cars_waiting < 65535) cars_waiting++;
               queued_seen = bump_cnt(queued_seen);
            end
         end
      end else if (w.op == OP_READ_OCC) begin
         if (w.bin_index <= SLOTS) r.bin_count = occ_bins[w.bin_index];
      end else if (w.op == OP_READ_QUEUE) begin
         r.bin_count = wait_bins[w.bin_index];
      end
      r.parked_count = 7'(cars_parked);
      r.queue_length = 16'(cars_waiting);
      r.arrivals_total = arrivals_seen;
      r.queued_total = queued_seen;
      r.queue_time_total = wait_accum;
      return r;
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      if (idx == CSR_ARRIVAL_RATE) lot_rate = 12'(value);
      else if (idx == CSR_SERVICE_TIME) lot_service = 16'(value);
      else if (idx == CSR_SPACE_COUNT) lot_spaces = 7'(value);
      @(negedge clock);
   endtask

   task automatic set_lot(input int unsigned rate, input int unsigned service,
                          input int unsigned spaces);
      csr_write(CSR_ARRIVAL_RATE, rate);
      csr_write(CSR_SERVICE_TIME, service);
      csr_write(CSR_SPACE_COUNT, spaces);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input req_type w, input bit typed, input rsp_type typed_rsp);
      int gap;
      rsp_type predicted;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = park_step(w);
      expected_rsps.insert(expected_rsps.size(), typed ? typed_rsp : predicted);
      words_sent++;
      if (w.op == OP_TICK) ticks_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic req_type random_word(int tick_pct);
      req_type w;
      if ($urandom_range(99) < tick_pct) w.op = OP_TICK;
      else if ($urandom_range(9) == 0) w.op = OP_UNUSED;
      else w.op = $urandom_range(1) ? OP_READ_OCC : OP_READ_QUEUE;
      w.random_draw = ($urandom_range(9) == 0) ? 12'($urandom_range(4095))
                                               : 12'($urandom_range(3600, 1));
      if (w.op == OP_READ_OCC && $urandom_range(4) != 0) w.bin_index = 8'($urandom_range(64));
      else if (w.op == OP_READ_QUEUE && $urandom_range(1)) w.bin_index = 8'($urandom_range(8));
      else w.bin_index = 8'($urandom);
      return w;
   endfunction

   task automatic run_words(input int count, input int tick_pct);
      for (int n = 0; n < count; n++) send_word(random_word(tick_pct), 1'b0, '0);
   endtask

   typedef struct {
      logic [1:0]  op;
      int          draw;
      int          bin;
      bit          typed;
      int          parked;
      int          waiting;
      longint      arrivals;
      longint      count;
   } row_type;

   // Rows run at the reset settings: rate 100, service 100, five spaces.
   row_type directed_rows [21] = '{
      '{OP_READ_OCC,   0,    0,   1, 0, 0, 0, 0},
      '{OP_READ_QUEUE, 0,    255, 1, 0, 0, 0, 0},
      '{OP_READ_OCC,   0,    65,  1, 0, 0, 0, 0},
      '{OP_UNUSED,     0,    0,   1, 0, 0, 0, 0},
      '{OP_TICK,       3600, 0,   1, 0, 0, 0, 0},
      '{OP_TICK,       1,    0,   1, 1, 0, 1, 0},
      '{OP_TICK,       100,  0,   1, 2, 0, 2, 0},
      '{OP_TICK,       101,  0,   1, 2, 0, 2, 0},
      '{OP_TICK,       4095, 0,   1, 2, 0, 2, 0},
      '{OP_TICK,       0,    0,   1, 3, 0, 3, 0},
      '{OP_READ_OCC,   0,    0,   1, 3, 0, 3, 2},
      '{OP_READ_OCC,   0,    2,   1, 3, 0, 3, 3},
      '{OP_READ_OCC,   0,    64,  1, 3, 0, 3, 0},
      '{OP_READ_QUEUE, 0,    0,   1, 3, 0, 3, 6},
      '{OP_READ_OCC,   0,    255, 1, 3, 0, 3, 0},
      '{OP_TICK,       50,   0,   0, 0, 0, 0, 0},
      '{OP_TICK,       50,   0,   0, 0, 0, 0, 0},
      '{OP_TICK,       50,   0,   0, 0, 0, 0, 0},
      '{OP_TICK,       3600, 0,   0, 0, 0, 0, 0},
      '{OP_READ_QUEUE, 0,    1,   0, 0, 0, 0, 0},
      '{OP_UNUSED,     0,    255, 0, 0, 0, 0, 0}
   };

   always @(negedge clock) begin
      if (receiver_hold > 0) begin
         rsp_ready <= 1'b0;
         receiver_hold = receiver_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%t: unexpected word %h", $realtime, rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            rsps_checked++;
            if (rsp_data.parked_count !== want.parked_count) begin
               $display("%t: parked_count expected %0d actual %0d", $realtime,
                        want.parked_count, rsp_data.parked_count);
               errors++;
            end
            if (rsp_data.queue_length !== want.queue_length) begin
               $display("%t: queue_length expected %0d actual %0d", $realtime,
                        want.queue_length, rsp_data.queue_length);
               errors++;
            end
            if (rsp_data.departed !== want.departed) begin
               $display("%t: departed expected %0d actual %0d", $realtime,
                        want.departed, rsp_data.departed);
               errors++;
            end
            if (rsp_data.arrival_queued !== want.arrival_queued) begin
               $display("%t: arrival_queued expected %0d actual %0d", $realtime,
                        want.arrival_queued, rsp_data.arrival_queued);
               errors++;
            end
            if (rsp_data.arrivals_total !== want.arrivals_total) begin
               $display("%t: arrivals_total expected %0d actual %0d", $realtime,
                        want.arrivals_total, rsp_data.arrivals_total);
               errors++;
            end
            if (rsp_data.queued_total !== want.queued_total) begin
               $display("%t: queued_total expected %0d actual %0d", $realtime,
                        want.queued_total, rsp_data.queued_total);
               errors++;
            end
            if (rsp_data.queue_time_total !== want.queue_time_total) begin
               $display("%t: queue_time_total expected %0d actual %0d", $realtime,
                        want.queue_time_total, rsp_data.queue_time_total);
               errors++;
            end
            if (rsp_data.bin_count !== want.bin_count) begin
               $display("%t: bin_count expected %0d actual %0d", $realtime,
                        want.bin_count, rsp_data.bin_count);
               errors++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("multi_server_queue_tick_simulator_core: mismatch");
      $finish;
   end

   initial begin
      req_type w;
      rsp_type typed_rsp;
      lot_rate = 12'd100;
      lot_service = 16'd100;
      lot_spaces = 7'd5;
      head_slot = 0;
      cars_parked = 0;
      cars_waiting = 0;
      arrivals_seen = '0;
      queued_seen = '0;
      wait_accum = '0;
      for (int i = 0; i < SLOTS; i++) car_timer[i] = '0;
      for (int i = 0; i <= SLOTS; i++) occ_bins[i] = '0;
      for (int i = 0; i < QBINS; i++) wait_bins[i] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct = 7;
      receiver_idle_pct = 68;
      foreach (directed_rows[k]) begin
         w.op = directed_rows[k].op;
         w.random_draw = 12'(directed_rows[k].draw);
         w.bin_index = 8'(directed_rows[k].bin);
         typed_rsp = '0;
         typed_rsp.parked_count = 7'(directed_rows[k].parked);
         typed_rsp.queue_length = 16'(directed_rows[k].waiting);
         typed_rsp.arrivals_total = 48'(directed_rows[k].arrivals);
         typed_rsp.bin_count = 40'(directed_rows[k].count);
         send_word(w, directed_rows[k].typed, typed_rsp);
      end
      settle();

      // The lot fills beyond 64 requested spaces; the receiver stalls long enough
      // for the block to back up onto its input.
      set_lot(3600, 20, 127);
      receiver_hold = 400;
      run_words(400, 70);
      settle();

      // Capacity drops below occupancy; cars entered with zero service time.
      set_lot(1800, 0, 3);
      run_words(300, 70);
      settle();

      sender_idle_pct = 68;
      receiver_idle_pct = 7;
      set_lot(0, 1, 0);
      run_words(200, 70);
      settle();
      set_lot(3000, 65535, 1);
      run_words(150, 70);
      settle();
      set_lot(2000, 7, 9);
      run_words(300, 70);
      settle();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_lot(2400, 5, 8);
      run_words(300, 75);
      settle();
      run_words(100, 75);
      settle();

      // No spaces and certain arrivals: every arrival queues.
      set_lot(4095, 3, 0);
      run_words(100, 99);
      settle();

      set_lot(4095, 65535, 64);
      receiver_hold = 300;
      run_words(250, 80);
      settle();

      $display("Sent %0d words (%0d ticks), checked %0d results over several lot settings,",
               words_sent, ticks_sent, rsps_checked);
      $display("including a full lot, an empty lot and a lot with no spaces at all.");
      if (errors == 0) begin
         $display("multi_server_queue_tick_simulator_core: match");
      end else begin
         $display("multi_server_queue_tick_simulator_core: mismatch");
      end
      $finish;
   end

endmodule
